@@ design/ewma_rate_window_controller_core_defines.svh @@
// Assertion macros shared by the rate window controller RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef EWMA_RATE_WINDOW_CONTROLLER_CORE_DEFINES_SVH
`define EWMA_RATE_WINDOW_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication.
`define EWRC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EWRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ewrc_pkg.sv @@
// Shared widths, constants, codes and controller/datapath interface types
// for the rate window controller. No dependencies.
package ewrc_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned GAIN_W     = 17;
  localparam int unsigned BIAS_W     = 16;
  localparam int unsigned DLY_W      = 16;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned LB_W       = 17;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned DIV_W      = 32;
  localparam int unsigned DIV_CNT_W  = 6;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [GAIN_W-1:0] Q16_ONE         = 17'h1_0000;
  localparam logic [TIME_W-1:0] NO_ONEWAY_DELAY = 32'd252525;
  localparam logic [DIV_W-1:0]  LB_DIVIDEND     = 32'h8000_0000; // 65536 in the top 17 bits
  localparam logic [DIV_CNT_W-1:0] LB_STEPS     = 6'd17;
  localparam logic [DIV_CNT_W-1:0] FULL_STEPS   = 6'd32;
  localparam logic [CNT_W-1:0]  CNT_MAX         = 16'hFFFF;

  localparam logic [LEN_W-1:0]  TICK_LENGTH_RST = 16'd20;
  localparam logic [GAIN_W-1:0] EWMA_GAIN_RST   = 17'd8192;
  localparam logic [BIAS_W-1:0] BIAS_SCALE_RST  = 16'd3277;
  localparam logic [DLY_W-1:0]  SAFE_DELAY_RST  = 16'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_TICK_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EWMA_GAIN   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_SCALE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFE_DELAY  = 8'd3;

  typedef enum logic [1:0] {
    DIV_LB  = 2'd0,
    DIV_REC = 2'd1,
    DIV_MOD = 2'd2
  } div_op_e;

  typedef struct packed {
    logic    load_in;
    logic    check;
    logic    div_start;
    div_op_e div_op;
    logic    blend_mul1;
    logic    blend_mul2;
    logic    blend_sum;
    logic    rate_upd;
    logic    win_fac;
    logic    win_mul_a;
    logic    win_mul_lo;
    logic    win_mul_hi;
    logic    win_fin;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic due;
    logic delay_nz;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

@@ design/ewrc_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle, step count per job.
// Depends on ewrc_pkg and the assertion macro header.
`include "ewma_rate_window_controller_core_defines.svh"

module ewrc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ewrc_pkg::DIV_W-1:0]      dividend_i,
  input  logic [ewrc_pkg::DIV_W-1:0]      divisor_i,
  input  logic [ewrc_pkg::DIV_CNT_W-1:0]  steps_i,
  output logic                            done_o,
  output logic [ewrc_pkg::DIV_W-1:0]      quot_o,
  output logic [ewrc_pkg::DIV_W-1:0]      rem_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [ewrc_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [ewrc_pkg::DIV_W-1:0]     dvd_q, dvs_q, rem_q, quo_q;
  logic [ewrc_pkg::DIV_W:0]       shifted, diff;
  logic                           ge;

  assign shifted = {rem_q, dvd_q[ewrc_pkg::DIV_W-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = steps_i;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ewrc_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[ewrc_pkg::DIV_W-2:0], 1'b0};
      rem_q <= ge ? diff[ewrc_pkg::DIV_W-1:0] : shifted[ewrc_pkg::DIV_W-1:0];
      quo_q <= {quo_q[ewrc_pkg::DIV_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

  `EWRC_ASSERT_IMPL(a_div_start_idle, start_i, !busy_q, "divider started while busy")
  `EWRC_ASSERT_IMPL(a_div_done_idle, done_q, !busy_q, "divider done while still busy")
  `EWRC_ASSERT_IMPL(a_div_cnt_live, busy_q, cnt_q != '0, "divider busy with no steps left")

endmodule

@@ design/ewrc_dp.sv @@
// Datapath: config registers, tick state, shared multiplier, divider and
// output register. Depends on ewrc_pkg, ewrc_div and the macro header.
`include "ewma_rate_window_controller_core_defines.svh"

module ewrc_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [ewrc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ewrc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [ewrc_pkg::IN_DATA_W-1:0]    in_data_i,
  input  logic                              in_cmd_i,
  input  ewrc_pkg::dp_cmd_t                 cmd_i,
  output ewrc_pkg::dp_status_t              status_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ewrc_pkg::OUT_DATA_W-1:0]   out_data_o
);

  localparam int unsigned TW = ewrc_pkg::TIME_W;

  logic [ewrc_pkg::LEN_W-1:0]  tick_len_q;
  logic [ewrc_pkg::GAIN_W-1:0] gain_q;
  logic [ewrc_pkg::BIAS_W-1:0] bias_q;
  logic [ewrc_pkg::DLY_W-1:0]  sdelay_q;

  logic [ewrc_pkg::CNT_W-1:0]  cnt_q;
  logic [TW-1:0]               start_q;
  logic [TW-1:0]               rate_q;
  logic [ewrc_pkg::CNT_W-1:0]  run_above_q, run_below_q;

  logic          cmd_q;
  logic [TW-1:0] t_q, snd_q, rcv_q, delay_q;
  logic [ewrc_pkg::LB_W-1:0] lb_q;
  logic [TW-1:0] recent_q, blend_q, fac_q;
  logic [ewrc_pkg::PROD_W-1:0] prod_q, acc_q;
  logic [ewrc_pkg::WIN_W-1:0]  ahi_q, win_q;
  logic                        out_valid_q;
  logic [ewrc_pkg::OUT_DATA_W-1:0] out_data_q;

  logic [ewrc_pkg::LEN_W-1:0]  len;
  logic [ewrc_pkg::GAIN_W-1:0] g_eff, g_inv;
  logic [TW-1:0] rtt, oneway, dmin, delay_d, elapsed, len_ext;
  logic          due_d;
  logic [ewrc_pkg::DIV_W-1:0]     div_dvd, div_dvs, div_quot, div_rem;
  logic [ewrc_pkg::DIV_CNT_W-1:0] div_steps;
  logic                           div_done;
  logic [TW-1:0] lb_ext, recent_d, rate_new, mul_a, mul_b, fac_d, p32;
  logic [ewrc_pkg::PROD_W-1:0] prod_d, blend_acc;
  logic          above_ge;
  logic [ewrc_pkg::CNT_W-1:0] mag;
  logic [48:0]   wsum;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_len_q <= ewrc_pkg::TICK_LENGTH_RST;
      gain_q     <= ewrc_pkg::EWMA_GAIN_RST;
      bias_q     <= ewrc_pkg::BIAS_SCALE_RST;
      sdelay_q   <= ewrc_pkg::SAFE_DELAY_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ewrc_pkg::CFG_TICK_LENGTH: tick_len_q <= cfg_data_i[ewrc_pkg::LEN_W-1:0];
        ewrc_pkg::CFG_EWMA_GAIN:   gain_q     <= cfg_data_i;
        ewrc_pkg::CFG_BIAS_SCALE:  bias_q     <= cfg_data_i[ewrc_pkg::BIAS_W-1:0];
        ewrc_pkg::CFG_SAFE_DELAY:  sdelay_q   <= cfg_data_i[ewrc_pkg::DLY_W-1:0];
        default: ;
      endcase
    end
  end

  assign len     = (tick_len_q == '0) ? ewrc_pkg::LEN_W'(1) : tick_len_q;
  assign len_ext = {{(TW-ewrc_pkg::LEN_W){1'b0}}, len};
  assign g_eff   = (gain_q > ewrc_pkg::Q16_ONE) ? ewrc_pkg::Q16_ONE : gain_q;
  assign g_inv   = ewrc_pkg::Q16_ONE - g_eff;

  // delay and tick check
  assign rtt     = t_q - snd_q;
  assign oneway  = (rcv_q > snd_q) ? (rcv_q - snd_q) : ewrc_pkg::NO_ONEWAY_DELAY;
  assign dmin    = (oneway < rtt) ? oneway : rtt;
  assign delay_d = cmd_q ? dmin : '0;
  assign elapsed = t_q - start_q;
  assign due_d   = elapsed >= len_ext;

  // divider operands
  always_comb begin
    unique case (cmd_i.div_op)
      ewrc_pkg::DIV_LB: begin
        div_dvd   = ewrc_pkg::LB_DIVIDEND;
        div_dvs   = delay_q;
        div_steps = ewrc_pkg::LB_STEPS;
      end
      ewrc_pkg::DIV_REC: begin
        div_dvd   = {cnt_q, {(TW-ewrc_pkg::CNT_W){1'b0}}};
        div_dvs   = len_ext;
        div_steps = ewrc_pkg::FULL_STEPS;
      end
      ewrc_pkg::DIV_MOD: begin
        div_dvd   = t_q;
        div_dvs   = len_ext;
        div_steps = ewrc_pkg::FULL_STEPS;
      end
      default: begin
        div_dvd   = ewrc_pkg::LB_DIVIDEND;
        div_dvs   = delay_q;
        div_steps = ewrc_pkg::LB_STEPS;
      end
    endcase
  end

  ewrc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .steps_i    (div_steps),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign lb_ext   = {{(TW-ewrc_pkg::LB_W){1'b0}}, lb_q};
  assign recent_d = (div_quot < lb_ext) ? lb_ext : div_quot;

  // shared multiplier
  assign above_ge = run_above_q >= run_below_q;
  assign mag      = above_ge ? (run_above_q - run_below_q) : (run_below_q - run_above_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.blend_mul1) begin
      mul_a = rate_q;
      mul_b = {{(TW-ewrc_pkg::GAIN_W){1'b0}}, g_inv};
    end else if (cmd_i.blend_mul2) begin
      mul_a = recent_q;
      mul_b = {{(TW-ewrc_pkg::GAIN_W){1'b0}}, g_eff};
    end else if (cmd_i.win_fac) begin
      mul_a = {{(TW-ewrc_pkg::BIAS_W){1'b0}}, bias_q};
      mul_b = {{(TW-ewrc_pkg::CNT_W){1'b0}}, mag};
    end else if (cmd_i.win_mul_a) begin
      mul_a = rate_q;
      mul_b = {{(TW-ewrc_pkg::DLY_W){1'b0}}, sdelay_q};
    end else if (cmd_i.win_mul_lo) begin
      mul_a = prod_q[TW-1:0];
      mul_b = fac_q;
    end else if (cmd_i.win_mul_hi) begin
      mul_a = {{(TW-ewrc_pkg::WIN_W){1'b0}}, ahi_q};
      mul_b = fac_q;
    end
  end

  assign prod_d    = {{TW{1'b0}}, mul_a} * {{TW{1'b0}}, mul_b};
  assign blend_acc = acc_q + prod_q;
  assign rate_new  = (blend_q < lb_ext) ? lb_ext : blend_q;

  // window factor 65536 + b*(above-below), clamped at zero
  assign p32 = prod_q[TW-1:0];
  always_comb begin
    if (above_ge) begin
      fac_d = p32 + TW'(ewrc_pkg::Q16_ONE);
    end else if (p32 >= TW'(ewrc_pkg::Q16_ONE)) begin
      fac_d = '0;
    end else begin
      fac_d = TW'(ewrc_pkg::Q16_ONE) - p32;
    end
  end

  // (a*f) >> 32 = a_hi*f + ((a_lo*f) >> 32)
  assign wsum = {1'b0, prod_q[47:0]} + {17'b0, acc_q[63:32]};

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load_in) begin
      cmd_q <= in_cmd_i;
      t_q   <= in_data_i[TW-1:0];
      snd_q <= in_data_i[2*TW-1:TW];
      rcv_q <= in_data_i[3*TW-1:2*TW];
    end
    if (cmd_i.check) begin
      delay_q <= delay_d;
      lb_q    <= '0;
    end
    if (div_done && cmd_i.div_op == ewrc_pkg::DIV_LB) begin
      lb_q <= div_quot[ewrc_pkg::LB_W-1:0];
    end
    if (div_done && cmd_i.div_op == ewrc_pkg::DIV_REC) begin
      recent_q <= recent_d;
    end
    if (cmd_i.blend_mul2 || cmd_i.win_mul_hi) begin
      acc_q <= prod_q;
    end
    if (cmd_i.blend_sum) begin
      blend_q <= blend_acc[47:16];
    end
    if (cmd_i.win_mul_a) begin
      fac_q <= fac_d;
    end
    if (cmd_i.win_mul_lo) begin
      ahi_q <= prod_q[47:32];
    end
    if (cmd_i.win_fin) begin
      win_q <= (|wsum[48:16]) ? '1 : wsum[15:0];
    end
  end

  // tick state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      start_q     <= '0;
      rate_q      <= '0;
      run_above_q <= '0;
      run_below_q <= '0;
    end else begin
      if (div_done && cmd_i.div_op == ewrc_pkg::DIV_MOD) begin
        start_q <= t_q - div_rem;
      end
      if (cmd_i.rate_upd) begin
        rate_q <= rate_new;
        cnt_q  <= '0;
        if (recent_q > rate_new) begin
          run_above_q <= (run_above_q == ewrc_pkg::CNT_MAX) ? run_above_q
                                                            : run_above_q + 1'b1;
          run_below_q <= '0;
        end else begin
          run_below_q <= (run_below_q == ewrc_pkg::CNT_MAX) ? run_below_q
                                                            : run_below_q + 1'b1;
          run_above_q <= '0;
        end
      end
      if (cmd_i.win_fac && cmd_q && cnt_q != ewrc_pkg::CNT_MAX) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= {rate_q, win_q};
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;
  assign status_o.due      = due_d;
  assign status_o.delay_nz = delay_d != '0;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  `EWRC_ASSERT_IMPL(a_out_no_overwrite, cmd_i.out_load, !out_valid_q || out_ready_i,
                    "result register overwritten")
  `EWRC_ASSERT_NEXT(a_rate_floor, cmd_i.rate_upd, rate_q >= lb_ext, "estimate below floor")
  `EWRC_ASSERT_NEXT(a_runs_exclusive, cmd_i.rate_upd, run_above_q == '0 || run_below_q == '0,
                    "both bias runs nonzero")

endmodule

@@ design/ewrc_ctrl.sv @@
// Sequencer for one event: tick check, up to three divides, EWMA blend, window.
// Depends on ewrc_pkg.
module ewrc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ewrc_pkg::dp_status_t  status_i,
  output ewrc_pkg::dp_cmd_t     cmd_o
);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_CHECK    = 18'h00002,
    S_LB_GO    = 18'h00004,
    S_LB_WAIT  = 18'h00008,
    S_REC_GO   = 18'h00010,
    S_REC_WAIT = 18'h00020,
    S_MOD_GO   = 18'h00040,
    S_MOD_WAIT = 18'h00080,
    S_BL1      = 18'h00100,
    S_BL2      = 18'h00200,
    S_BL3      = 18'h00400,
    S_UPD      = 18'h00800,
    S_WIN1     = 18'h01000,
    S_WIN2     = 18'h02000,
    S_WIN3     = 18'h04000,
    S_WIN4     = 18'h08000,
    S_WIN5     = 18'h10000,
    S_OUT      = 18'h20000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.div_op = ewrc_pkg::DIV_LB;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        if (!status_i.due) begin
          state_d = S_WIN1;
        end else if (status_i.delay_nz) begin
          state_d = S_LB_GO;
        end else begin
          state_d = S_REC_GO;
        end
      end
      S_LB_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = S_LB_WAIT;
      end
      S_LB_WAIT: begin
        if (status_i.div_done) state_d = S_REC_GO;
      end
      S_REC_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op = ewrc_pkg::DIV_REC;
        state_d = S_REC_WAIT;
      end
      S_REC_WAIT: begin
        cmd_o.div_op = ewrc_pkg::DIV_REC;
        if (status_i.div_done) state_d = S_MOD_GO;
      end
      S_MOD_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op = ewrc_pkg::DIV_MOD;
        state_d = S_MOD_WAIT;
      end
      S_MOD_WAIT: begin
        cmd_o.div_op = ewrc_pkg::DIV_MOD;
        if (status_i.div_done) state_d = S_BL1;
      end
      S_BL1: begin
        cmd_o.blend_mul1 = 1'b1;
        state_d = S_BL2;
      end
      S_BL2: begin
        cmd_o.blend_mul2 = 1'b1;
        state_d = S_BL3;
      end
      S_BL3: begin
        cmd_o.blend_sum = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.rate_upd = 1'b1;
        state_d = S_WIN1;
      end
      S_WIN1: begin
        cmd_o.win_fac = 1'b1;
        state_d = S_WIN2;
      end
      S_WIN2: begin
        cmd_o.win_mul_a = 1'b1;
        state_d = S_WIN3;
      end
      S_WIN3: begin
        cmd_o.win_mul_lo = 1'b1;
        state_d = S_WIN4;
      end
      S_WIN4: begin
        cmd_o.win_mul_hi = 1'b1;
        state_d = S_WIN5;
      end
      S_WIN5: begin
        cmd_o.win_fin = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

@@ design/ewma_rate_window_controller_core.sv @@
// Top level of the EWMA rate window controller: sequencer plus datapath.
// Depends on ewrc_pkg, ewrc_ctrl, ewrc_dp (and ewrc_div below it).
//
//  channel   direction  signals                       transaction
//  --------  ---------  ----------------------------  ------------------------------
//  cfg       in         cfg_valid_i/ready_o/index/data register write
//  s_axis    in         s_axis_tvalid/tready/tdata/tuser one sent or ack event
//  m_axis    out        m_axis_tvalid/tready/tdata    window and rate estimate
//
// An event that closes no tick skips the divider and the blend. When a tick closes,
// the radix-2 divider runs 17 steps for the 1/delay floor (ack events with a nonzero
// delay only) and 32 each for the tick rate and the tick realign.
// A new event is taken the cycle after the result is loaded, even while it waits.
// Reset is asynchronous, active low, and restores the register defaults.
// A stalled result holds the sequencer in its last step until m_axis_tready frees it.
module ewma_rate_window_controller_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ewrc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ewrc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] event_time, [63:32] acked_send_time, [95:64] acked_receive_time
  input  logic [ewrc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] command
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] window_packets, [47:16] rate_estimate
  output logic [ewrc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  ewrc_pkg::dp_cmd_t    cmd;
  ewrc_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  ewrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ewrc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_cmd_i    (s_axis_tuser[0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

@@ tb/sv/ewrc_window_checker.sv @@
// Checker for the EWMA rate window controller: tracks register writes and events,
// predicts each window/rate result and compares it with the m_axis stream.
// Depends on ewrc_pkg.
module ewrc_window_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [ewrc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ewrc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [ewrc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic [0:0]                        s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [ewrc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);
  import ewrc_pkg::*;

  typedef struct packed {
    logic [WIN_W-1:0]  window;
    logic [TIME_W-1:0] rate;
  } window_rate_t;

  logic [LEN_W-1:0]  tick_len_r;
  logic [GAIN_W-1:0] gain_r;
  logic [BIAS_W-1:0] bias_r;
  logic [DLY_W-1:0]  safe_delay_r;

  logic [CNT_W-1:0]  acks_in_tick;
  logic [TIME_W-1:0] tick_start;
  logic [TIME_W-1:0] rate_est;
  logic [CNT_W-1:0]  runs_above;
  logic [CNT_W-1:0]  runs_below;

  window_rate_t expected_q[$];
  int unsigned  errors = 0;

  function automatic logic [CNT_W-1:0] bump16(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

  function automatic void close_tick(input logic [31:0] now, input logic [31:0] delay);
    logic [31:0] len, lb, recent, blended;
    logic [63:0] g, mix;
    len = (tick_len_r == '0) ? 32'd1 : 32'(tick_len_r);
    g   = (gain_r > Q16_ONE) ? 64'd65536 : 64'(gain_r);
    if (now - tick_start >= len) begin
      lb     = (delay == 32'd0) ? 32'd0 : 32'h0001_0000 / delay;
      recent = 32'((64'(acks_in_tick) << 16) / 64'(len));
      if (recent < lb) recent = lb;
      mix      = (64'd65536 - g) * 64'(rate_est) + g * 64'(recent);
      blended  = mix[47:16];
      rate_est = (blended < lb) ? lb : blended;
      if (recent > rate_est) begin
        runs_above = bump16(runs_above);
        runs_below = '0;
      end else begin
        runs_below = bump16(runs_below);
        runs_above = '0;
      end
      acks_in_tick = '0;
      tick_start   = now - (now % len);
    end
  endfunction

  function automatic logic [WIN_W-1:0] window_now();
    longint      factor;
    logic [63:0] a, f, w;
    factor = 64'sd65536
           + longint'(bias_r) * (longint'(runs_above) - longint'(runs_below));
    if (factor <= 0) return '0;
    a = 64'(rate_est) * 64'(safe_delay_r);
    if (a == 64'd0) return '0;
    f = 64'(factor);
    if (f > 64'hFFFF_FFFF_FFFF_FFFF / a) return 16'hFFFF;
    w = (a * f) >> 32;
    return (w > 64'd65535) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic window_rate_t apply_event(input logic cmd, input logic [31:0] t,
                                               input logic [31:0] snd,
                                               input logic [31:0] rcv);
    logic [31:0]  rtt, oneway;
    window_rate_t r;
    if (!cmd) begin
      close_tick(t, 32'd0);
    end else begin
      rtt    = t - snd;
      oneway = (rcv > snd) ? rcv - snd : NO_ONEWAY_DELAY;
      close_tick(t, (oneway < rtt) ? oneway : rtt);
      acks_in_tick = bump16(acks_in_tick);
    end
    r.window = window_now();
    r.rate   = rate_est;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    window_rate_t seen, want;
    if (!rst_ni) begin
      tick_len_r   = TICK_LENGTH_RST;
      gain_r       = EWMA_GAIN_RST;
      bias_r       = BIAS_SCALE_RST;
      safe_delay_r = SAFE_DELAY_RST;
      acks_in_tick = '0;
      tick_start   = '0;
      rate_est     = '0;
      runs_above   = '0;
      runs_below   = '0;
      expected_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TICK_LENGTH: tick_len_r   = cfg_data_i[LEN_W-1:0];
          CFG_EWMA_GAIN:   gain_r       = cfg_data_i[GAIN_W-1:0];
          CFG_BIAS_SCALE:  bias_r       = cfg_data_i[BIAS_W-1:0];
          CFG_SAFE_DELAY:  safe_delay_r = cfg_data_i[DLY_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.window = m_axis_tdata[15:0];
        seen.rate   = m_axis_tdata[47:16];
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result window %0d rate 0x%08h",
                     $realtime, seen.window, seen.rate);
        end else begin
          want = expected_q.pop_front();
          if (want.window !== seen.window || want.rate !== seen.rate) begin
            errors++;
            if (errors <= 10)
              $display("%0t: result mismatch, window exp %0d got %0d, rate exp 0x%08h got 0x%08h",
                       $realtime, want.window, seen.window, want.rate, seen.rate);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(apply_event(s_axis_tuser[0], s_axis_tdata[31:0],
                                         s_axis_tdata[63:32], s_axis_tdata[95:64]));
      pending_o    <= expected_q.size();
      fail_count_o <= errors;
    end
  end

endmodule

@@ tb/sv/ewma_rate_window_controller_core_tb.sv @@
// Top of the rate window controller testbench: clock, reset, event and register
// stimulus, receiver back-pressure, watchdog and verdict.
// Depends on ewrc_pkg, ewma_rate_window_controller_core and ewrc_window_checker.
module ewma_rate_window_controller_core_tb;
  import ewrc_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  int unsigned fail_count, pending;
  int unsigned gap_odds = 3, stall_odds = 3;
  int unsigned hold_requests = 0, holds_served = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tick_cfg = 20;
  logic [31:0] now_ms = '0;

  ewma_rate_window_controller_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ewrc_window_checker window_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cfg_valid_i && cfg_ready_o) || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result receiver: random stall bursts, plus long holds on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (holds_served != hold_requests) begin
        holds_served++;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic offer_event(input logic cmd, input logic [31:0] t, input logic [31:0] snd,
                             input logic [31:0] rcv);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {rcv, snd, t};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] tick, input logic [CFG_DATA_W-1:0] gain,
                              input logic [CFG_DATA_W-1:0] bias,
                              input logic [CFG_DATA_W-1:0] delay);
    logic [CFG_DATA_W-1:0] vals[4];
    logic [CFG_IDX_W-1:0]  idxs[4];
    vals = '{tick, gain, bias, delay};
    idxs = '{CFG_TICK_LENGTH, CFG_EWMA_GAIN, CFG_BIAS_SCALE, CFG_SAFE_DELAY};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idxs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    tick_cfg = {16'd0, tick[15:0]};
  endtask

  // mostly well-formed traffic on a running clock, some pure noise
  task automatic random_event();
    int unsigned len, kind;
    logic [31:0] rtt, snd, rcv;
    len  = (tick_cfg == 0) ? 1 : tick_cfg;
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      offer_event(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
    end else begin
      if (kind == 1) now_ms = now_ms + $urandom;
      else if (kind <= 5) now_ms = now_ms + $urandom_range(len, 3 * len);
      else now_ms = now_ms + $urandom_range(0, len / 2);
      if ($urandom_range(0, 3) == 0) begin
        offer_event(1'b0, now_ms, $urandom, $urandom);
      end else begin
        rtt = $urandom_range(0, 300);
        snd = now_ms - rtt;
        case ($urandom_range(0, 7))
          0:       rcv = snd - $urandom_range(0, 5);
          1:       rcv = $urandom;
          default: rcv = snd + $urandom_range(1, rtt + 20);
        endcase
        offer_event(1'b1, now_ms, snd, rcv);
      end
    end
  endtask

  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);

    // directed events at the reset register values
    offer_event(1'b0, 32'd0, 32'd0, 32'd0);
    offer_event(1'b1, 32'd5, 32'd1, 32'd3);
    offer_event(1'b1, 32'd25, 32'd20, 32'd21);
    offer_event(1'b1, 32'd26, 32'd26, 32'd26);
    offer_event(1'b1, 32'd50, 32'd45, 32'd45);
    offer_event(1'b1, 32'd70, 32'hFFFF_FFF0, 32'd0);
    offer_event(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_event(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_event(1'b1, 32'd10, 32'hFFFF_FFFC, 32'd2);
    for (int k = 0; k < 4; k++) offer_event(1'b1, 32'd200 + k, 32'd100, 32'd150);
    offer_event(1'b0, 32'd240, 32'd0, 32'd0);

    // zero tick length, zero gain, full bias: window runs into saturation
    drain();
    program_regs('0, '0, 17'hFFFF, 17'hFFFF);
    now_ms = 32'h0000_1000;
    repeat (3) offer_event(1'b1, now_ms, now_ms - 2, now_ms - 1);
    now_ms++;
    repeat (3) offer_event(1'b1, now_ms, now_ms - 2, now_ms - 1);
    now_ms++;
    offer_event(1'b1, now_ms, now_ms - 2, now_ms - 1);

    // gain above one: estimate follows the tick rate, bias goes negative
    drain();
    program_regs('0, 17'h1FFFF, 17'hFFFF, 17'hFFFF);
    repeat (3) begin
      now_ms++;
      offer_event(1'b1, now_ms, now_ms - 2, now_ms - 1);
    end

    // zero safe delay
    drain();
    program_regs({1'b0, TICK_LENGTH_RST}, EWMA_GAIN_RST, {1'b0, BIAS_SCALE_RST}, '0);
    now_ms = now_ms + 40;
    offer_event(1'b1, now_ms, now_ms - 5, now_ms - 2);
    offer_event(1'b0, now_ms + 1, 32'd0, 32'd0);

    // many acks within one long tick
    drain();
    program_regs(17'hFFFF, Q16_ONE, '0, {1'b0, SAFE_DELAY_RST});
    gap_odds   = 0;
    stall_odds = 0;
    now_ms     = 32'h0010_0000;
    for (int n = 0; n < 24; n++) offer_event(1'b1, now_ms, now_ms - 7, now_ms - 4);
    now_ms = now_ms + 32'd65535;
    offer_event(1'b0, now_ms, 32'd0, 32'd0);

    for (int phase = 0; phase < 5; phase++) begin
      logic [CFG_DATA_W-1:0] tick, gain, bias, delay;
      drain();
      case ($urandom_range(0, 5))
        0:       tick = 17'd1;
        1:       tick = 17'hFFFF;
        2:       tick = '0;
        default: tick = 17'($urandom_range(2, 60));
      endcase
      case ($urandom_range(0, 4))
        0:       gain = '0;
        1:       gain = Q16_ONE;
        2:       gain = 17'($urandom_range(65537, 131071));
        default: gain = 17'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 3))
        0:       bias = '0;
        1:       bias = 17'hFFFF;
        default: bias = 17'($urandom_range(0, 8000));
      endcase
      case ($urandom_range(0, 4))
        0:       delay = '0;
        1:       delay = 17'hFFFF;
        2:       delay = 17'd1;
        default: delay = 17'($urandom_range(2, 500));
      endcase
      if (phase == 4) program_regs(tick, gain, bias, {1'b0, SAFE_DELAY_RST});
      else program_regs(tick, gain, bias, delay);
      if ($urandom_range(0, 1) == 1) now_ms = $urandom;
      for (int n = 0; n < 160; n++) begin
        if (n % 40 == 0) begin
          gap_odds   = (phase == 4) ? 0 : $urandom_range(0, 6);
          stall_odds = (phase == 4) ? 0 : $urandom_range(0, 6);
        end
        if (phase == 1 && n == 60) hold_requests++;
        random_event();
      end
    end

    drain();
    repeat (120) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
